>>> rtl/cbez_pkg.sv
// cbez_pkg: operation codes, sequencer states and transaction structs
// for the cubic bezier evaluator; no dependencies
`default_nettype none
package cbez_pkg;

  localparam int CW = 32;
  localparam int PF = 16;

  typedef enum logic [2:0] {
    OP_LOAD_A  = 3'd0,
    OP_LOAD_TA = 3'd1,
    OP_LOAD_D  = 3'd2,
    OP_LOAD_TD = 3'd3,
    OP_EVAL    = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTRL,
    ST_LERP,
    ST_LERP_WB,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]           operation;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
    logic [PF:0]          curve_param;
  } cbez_in_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [31:0]   dir_x;
    logic signed [31:0]   dir_y;
    logic signed [31:0]   dir_z;
    logic                 tangent_zero;
  } cbez_out_t;

endpackage
`default_nettype wire

>>> rtl/cbez_divsqrt.sv
// cbez_divsqrt: shared bit-serial unit, one quotient or root bit per cycle
// depends on nothing but its ports
`default_nettype none
module cbez_divsqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic        is_sqrt,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [63:0]      res
);
  // restoring division (64 steps) or digit-by-digit root (32 steps)
  logic [6:0]  cnt;
  logic        busy;
  logic        mode;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [31:0] dv;
  logic [64:0] trial;
  logic [64:0] rem_sh;

  always_comb begin
    if (mode) begin
      rem_sh = {rem[62:0], quo[63:62]};
      trial  = rem_sh - {res[62:0], 2'b01};
    end else begin
      rem_sh = {rem[63:0], quo[63]};
      trial  = rem_sh - {33'd0, dv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        mode <= is_sqrt;
        quo  <= num;
        dv   <= den;
        rem  <= '0;
        res  <= '0;
        cnt  <= is_sqrt ? 7'd32 : 7'd64;
      end else if (busy) begin
        quo <= mode ? {quo[61:0], 2'b00} : {quo[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial;
          res <= {res[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          res <= {res[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/cubic_bezier_point_tangent.sv
// cubic_bezier_point_tangent: top level, sequencer, operand registers and
// a multiplier shared by all lerps; uses cbez_pkg and cbez_divsqrt
// load transactions never raise busy. an evaluate keeps busy high through 3
// control-point steps, 18 lerps (multiply, then write-back), normalize, 3
// squares, a root and three divides on the shared bit-serial unit; with a zero
// tangent, normalize goes straight to done. the strobe comes in the same cycle
// as busy falls; a new evaluate is taken only once busy is low. the receiver
// cannot stall. synchronous reset clears the four stored vectors and sequencer
`default_nettype none
module cubic_bezier_point_tangent
  import cbez_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire cbez_in_t  in_item,
  output logic           busy,
  output logic           strobe,
  output cbez_out_t      result
);

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  state_t state, state_next;

  // control points indexed [point][axis]: a b c d, then ab bc cd abbc bccd pos
  logic signed [CW-1:0] pt [10][3];
  logic signed [CW-1:0] ta [3];
  logic signed [CW-1:0] td [3];
  logic [PF:0]          u;
  logic [2:0]           step;   // lerp within one axis 0..5
  logic [1:0]           ax;
  logic [63:0]          mag [3];
  logic [2:0]           neg;
  logic [63:0]          sum;
  logic [31:0]          len;
  logic signed [31:0]   dir [3];
  logic                 zflag;
  logic                 du_go, du_sqrt, du_done;
  logic [63:0]          du_num, du_res;
  logic                 du_wait;

  // shared multiplier: magnitude times u, one product per lerp
  logic [CW:0]          lp_mag;
  logic [CW+PF+1:0]     lp_prod;
  logic [CW+PF+1:0]     lp_round;
  logic [CW-1:0]        lp_scaled;
  logic [3:0]           src_p, src_q, dst;
  logic signed [CW-1:0] pv, qv;
  logic                 lp_neg;

  // tangent difference bccd - abbc and its magnitude
  logic signed [CW:0]   tdiff [3];
  logic [CW:0]          tabs [3];

  // normalize shift from the largest magnitude
  logic [63:0]          mx;
  logic [6:0]           nbits;

  always_comb begin
    // step sequence: per axis ab, bc, cd, abbc, bccd, pos
    unique case (step)
      3'd0: begin src_p = 4'd0; src_q = 4'd1; dst = 4'd4; end
      3'd1: begin src_p = 4'd1; src_q = 4'd2; dst = 4'd5; end
      3'd2: begin src_p = 4'd2; src_q = 4'd3; dst = 4'd6; end
      3'd3: begin src_p = 4'd4; src_q = 4'd5; dst = 4'd7; end
      3'd4: begin src_p = 4'd5; src_q = 4'd6; dst = 4'd8; end
      default: begin src_p = 4'd7; src_q = 4'd8; dst = 4'd9; end
    endcase
  end

  assign pv = pt[src_p][ax];
  assign qv = pt[src_q][ax];
  assign lp_prod   = lp_mag * u;
  assign lp_round  = lp_prod + (CW+PF+2)'(1 << (PF-1));
  assign lp_scaled = lp_round[PF +: CW];

  // saturated sums for the inner control points
  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
    logic [CW:0] s;
    s = {x[CW-1], x} + {y[CW-1], y};
    if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
    return s[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_neg(input logic signed [CW-1:0] x);
    return (x == CMIN) ? CMAX : -x;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tdiff[i] = {pt[8][i][CW-1], pt[8][i]} - {pt[7][i][CW-1], pt[7][i]};
      tabs[i]  = tdiff[i][CW] ? -tdiff[i] : tdiff[i];
    end
  end

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    nbits = '0;
    for (int i = 0; i < 64; i++) if (mx[i]) nbits = 7'(i + 1);
  end

  assign du_num = {mag[ax][31:0], 30'd0} + {33'd0, len[31:1]};

  cbez_divsqrt u_ds (
    .clk(clk), .rst(rst), .go(du_go), .is_sqrt(du_sqrt),
    .num(du_sqrt ? sum : du_num), .den(len), .done(du_done), .res(du_res)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    du_go      = 1'b0;
    du_sqrt    = 1'b0;
    unique case (state)
      ST_IDLE:    if (start && in_item.operation == OP_EVAL) state_next = ST_CTRL;
      ST_CTRL:    if (ax == 2'd2) state_next = ST_LERP;
      ST_LERP:    state_next = ST_LERP_WB;
      ST_LERP_WB: state_next = (step == 3'd5 && ax == 2'd2) ? ST_NORM : ST_LERP;
      ST_NORM:    state_next = (nbits == 7'd0) ? ST_DONE : ST_SQ;
      ST_SQ:      if (ax == 2'd2) state_next = ST_SQRT;
      // launch the root once the sum of squares is complete
      ST_SQRT:    if (!du_wait) begin
                    du_go = 1'b1;
                    du_sqrt = 1'b1;
                  end else if (du_done) begin
                    state_next = ST_DIV;
                  end
      ST_DIV:     if (!du_wait) du_go = 1'b1;
                  else if (du_done && ax == 2'd2) state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pt[0][i] <= '0; pt[3][i] <= '0; ta[i] <= '0; td[i] <= '0;
      end
      step <= '0; ax <= '0; strobe <= 1'b0; du_wait <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          ax <= '0; step <= '0; du_wait <= 1'b0;
          if (start) begin
            unique case (in_item.operation)
              OP_LOAD_A:  begin pt[0][0] <= in_item.vec_x; pt[0][1] <= in_item.vec_y;
                                pt[0][2] <= in_item.vec_z; end
              OP_LOAD_TA: begin ta[0] <= in_item.vec_x; ta[1] <= in_item.vec_y;
                                ta[2] <= in_item.vec_z; end
              OP_LOAD_D:  begin pt[3][0] <= in_item.vec_x; pt[3][1] <= in_item.vec_y;
                                pt[3][2] <= in_item.vec_z; end
              OP_LOAD_TD: begin td[0] <= in_item.vec_x; td[1] <= in_item.vec_y;
                                td[2] <= in_item.vec_z; end
              OP_EVAL:    u <= (in_item.curve_param > (PF+1)'(1 << PF))
                                 ? (PF+1)'(1 << PF) : in_item.curve_param;
              default: ;
            endcase
          end
        end
        ST_CTRL: begin
          pt[1][ax] <= sat_add(pt[0][ax], ta[ax]);
          pt[2][ax] <= sat_add(pt[3][ax], sat_neg(td[ax]));
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        ST_LERP: begin
          lp_neg  <= qv < pv;
          lp_mag  <= (qv < pv) ? ({pv[CW-1], pv} - {qv[CW-1], qv})
                               : ({qv[CW-1], qv} - {pv[CW-1], pv});
        end
        ST_LERP_WB: begin
          pt[dst][ax] <= lp_neg ? pv - lp_scaled : pv + lp_scaled;
          if (step == 3'd5) begin
            step <= '0;
            ax <= ax + 2'd1;
          end else begin
            step <= step + 3'd1;
          end
          // all abbc and bccd are final at the last write-back
          if (step == 3'd5 && ax == 2'd2) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= {{(63-CW){1'b0}}, tabs[i]};
              neg[i] <= tdiff[i][CW];
            end
          end
        end
        ST_NORM: begin
          ax <= '0; sum <= '0;
          for (int i = 0; i < 3; i++) begin
            if (nbits > 7'd31) mag[i] <= mag[i] >> (nbits - 7'd31);
            else               mag[i] <= mag[i] << (7'd31 - nbits);
          end
          zflag <= (nbits == 7'd0);
        end
        ST_SQ: begin
          sum <= sum + mag[ax][31:0] * mag[ax][31:0];
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        ST_SQRT: begin
          if (!du_wait) du_wait <= 1'b1;
          else if (du_done) begin
            len <= du_res[31:0];
            du_wait <= 1'b0;
          end
        end
        ST_DIV: begin
          if (!du_wait) du_wait <= 1'b1;
          else if (du_done) begin
            dir[ax] <= neg[ax] ? -du_res[31:0] : du_res[31:0];
            du_wait <= 1'b0;
            ax <= ax + 2'd1;
          end
        end
        ST_DONE: strobe <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy = (state != ST_IDLE);
    result.pos_x = pt[9][0];
    result.pos_y = pt[9][1];
    result.pos_z = pt[9][2];
    result.dir_x = zflag ? '0 : dir[0];
    result.dir_y = zflag ? '0 : dir[1];
    result.dir_z = zflag ? '0 : dir[2];
    result.tangent_zero = zflag;
  end

  a_one_strobe: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("strobe held");
  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("strobe without work");
  a_no_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LERP) |-> busy) else $error("busy low in lerp");

endmodule
`default_nettype wire

>>> tb/cubic_bezier_point_tangent_test.sv
// cubic_bezier_point_tangent_test: self-checking testbench for the cubic bezier
// point and tangent evaluator; uses cbez_pkg and the cubic_bezier_point_tangent rtl
`default_nettype none
module cubic_bezier_point_tangent_test;
  import cbez_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst;
  logic      start;
  cbez_in_t  in_item;
  logic      busy;
  logic      strobe;
  cbez_out_t result;

  cubic_bezier_point_tangent DUT (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .strobe(strobe), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predictor copy of the stored segment
  logic signed [63:0] seg_a [3];
  logic signed [63:0] seg_ta[3];
  logic signed [63:0] seg_d [3];
  logic signed [63:0] seg_td[3];

  cbez_out_t curve_queue[$];
  int        mismatch_count;
  int        eval_count;
  int        zero_tan_count;
  longint    cycle_count;
  bit        timed_out;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 4000000;

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // p + s * round(|q - p| * u / 2^F), all in 64 bits (values stay in 33 bits)
  function automatic longint interp(longint p, longint q, longint u);
    longint mag;
    longint step;
    mag = (q >= p) ? q - p : p - q;
    step = (mag * u + (64'sd1 <<< (PF - 1))) >>> PF;
    return (q >= p) ? p + step : p - step;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // expected point and tangent for one evaluate
  function automatic cbez_out_t predict_curve_point(logic [PF:0] param);
    cbez_out_t   r;
    longint      u;
    longint      pa, pb, pc, pd, ab, bc, cd, abbc, bccd, pt;
    logic [63:0] mag[3];
    logic [63:0] mx, sum, len, q;
    bit          neg[3];
    int          nbits;
    r = '0;
    u = (param > (1 << PF)) ? (64'sd1 <<< PF) : longint'(param);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      pa = seg_a[i];
      pd = seg_d[i];
      pb = clamp_coord(pa + seg_ta[i]);
      pc = clamp_coord(pd + clamp_coord(-seg_td[i]));
      ab = interp(pa, pb, u);
      bc = interp(pb, pc, u);
      cd = interp(pc, pd, u);
      abbc = interp(ab, bc, u);
      bccd = interp(bc, cd, u);
      pt = interp(abbc, bccd, u);
      neg[i] = bccd < abbc;
      mag[i] = neg[i] ? abbc - bccd : bccd - abbc;
      if (mag[i] > mx) mx = mag[i];
      case (i)
        0: r.pos_x = pt[31:0];
        1: r.pos_y = pt[31:0];
        default: r.pos_z = pt[31:0];
      endcase
    end
    if (mx == 0) begin
      r.tangent_zero = 1'b1;
      return r;
    end
    nbits = 0;
    while (mx != 0) begin
      nbits++;
      mx = mx >> 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (nbits > 31) mag[i] = mag[i] >> (nbits - 31);
      else if (nbits < 31) mag[i] = mag[i] << (31 - nbits);
      sum = sum + mag[i] * mag[i];
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      if (neg[i]) q = -q;
      case (i)
        0: r.dir_x = q[31:0];
        1: r.dir_y = q[31:0];
        default: r.dir_z = q[31:0];
      endcase
    end
    return r;
  endfunction

  // update the predictor for one accepted transaction
  task automatic model_transaction(cbez_in_t t);
    logic signed [63:0] v[3];
    v[0] = t.vec_x;
    v[1] = t.vec_y;
    v[2] = t.vec_z;
    case (t.operation)
      OP_LOAD_A:  seg_a  = v;
      OP_LOAD_TA: seg_ta = v;
      OP_LOAD_D:  seg_d  = v;
      OP_LOAD_TD: seg_td = v;
      OP_EVAL:    curve_queue.push_back(predict_curve_point(t.curve_param));
      default: ;  // codes 5..7 do nothing
    endcase
  endtask

  // result checker: strobe is sampled at the rising edge
  always @(posedge clk) begin
    cbez_out_t exp_r;
    if (!rst) cycle_count <= cycle_count + 1;
    if (!rst && strobe) begin
      if (curve_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", result);
      end else begin
        exp_r = curve_queue.pop_front();
        eval_count++;
        if (exp_r.tangent_zero) zero_tan_count++;
        if (result !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch pos exp %h %h %h got %h %h %h", exp_r.pos_x, exp_r.pos_y,
                     exp_r.pos_z, result.pos_x, result.pos_y, result.pos_z);
            $display("  dir exp %h %h %h z%b got %h %h %h z%b", exp_r.dir_x, exp_r.dir_y,
                     exp_r.dir_z, exp_r.tangent_zero, result.dir_x, result.dir_y,
                     result.dir_z, result.tangent_zero);
          end
        end
      end
    end
  end

  // run timeout
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one transaction: present at falling edge, busy is stable there, so the
  // next rising edge accepts once busy reads low
  task automatic send_transaction(cbez_in_t t);
    @(negedge clk);
    start <= 1'b1;
    in_item <= t;
    while (busy) @(negedge clk);
    @(posedge clk);
    model_transaction(t);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 255) << 16;
      3: return 32'($signed($urandom_range(0, 131071)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PF:0] rand_param();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1 << PF;
      2: return $urandom_range((1 << PF) + 1, (1 << (PF + 1)) - 1);
      default: return $urandom_range(0, 1 << PF);
    endcase
  endfunction

  function automatic cbez_in_t make_item(logic [2:0] op, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [PF:0] u);
    cbez_in_t t;
    t.operation = op;
    t.vec_x = x;
    t.vec_y = y;
    t.vec_z = z;
    t.curve_param = u;
    return t;
  endfunction

  // directed table; expected results come from the predictor
  cbez_in_t directed[$];

  initial begin
    cbez_in_t t;
    int n_items;
    logic [2:0] op;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    mismatch_count = 0;
    eval_count = 0;
    zero_tan_count = 0;
    cycle_count = 0;
    timed_out = 0;
    for (int i = 0; i < 3; i++) begin
      seg_a[i] = 0; seg_ta[i] = 0; seg_d[i] = 0; seg_td[i] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: zero segment, zero tangent flagged
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h08000));
    directed.push_back(make_item(OP_LOAD_A, 32'h00010000, 32'hffff0000, 0, 0));
    directed.push_back(make_item(OP_LOAD_TA, 32'h00030000, 0, 32'h00020000, 0));
    directed.push_back(make_item(OP_LOAD_D, 32'h00100000, 32'h00050000, 32'hfff00000, 0));
    directed.push_back(make_item(OP_LOAD_TD, 32'h00010000, 32'h00010000, 0, 0));
    directed.push_back(make_item(OP_EVAL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h10000));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h1ffff));  // above one
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h00001));
    directed.push_back(make_item(3'd5, 32'h7fffffff, 0, 0, 0));   // ignored codes
    directed.push_back(make_item(3'd6, 0, 32'h80000000, 0, 0));
    directed.push_back(make_item(3'd7, 0, 0, 32'h7fffffff, 0));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h04000));
    // saturating control points at the extremes
    directed.push_back(make_item(OP_LOAD_A, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
    directed.push_back(make_item(OP_LOAD_TA, 32'h7fffffff, 32'h80000000, 32'h80000000, 0));
    directed.push_back(make_item(OP_LOAD_D, 32'h80000000, 32'h7fffffff, 32'h80000000, 0));
    directed.push_back(make_item(OP_LOAD_TD, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h08000));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h00000));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h10000));
    // degenerate segment: all four points equal, tangent zero
    directed.push_back(make_item(OP_LOAD_A, 32'h00050000, 32'h00050000, 32'h00050000, 0));
    directed.push_back(make_item(OP_LOAD_TA, 0, 0, 0, 0));
    directed.push_back(make_item(OP_LOAD_D, 32'h00050000, 32'h00050000, 32'h00050000, 0));
    directed.push_back(make_item(OP_LOAD_TD, 0, 0, 0, 0));
    directed.push_back(make_item(OP_EVAL, 0, 0, 0, 17'h0c000));
    foreach (directed[i]) begin
      send_transaction(directed[i]);
      idle_gap();
    end

    // random part: mostly full reloads followed by evaluates, some noise
    n_items = 0;
    while (n_items < 1350) begin
      if ($urandom_range(0, 4) != 0) begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 7) != 0) begin
            send_transaction(make_item(k[2:0], rand_coord(), rand_coord(), rand_coord(),
                                       17'($urandom)));
            n_items++;
            idle_gap();
          end
        end
      end
      repeat ($urandom_range(1, 3)) begin
        op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'(OP_EVAL);
        send_transaction(make_item(op, $urandom, $urandom, $urandom, rand_param()));
        if (op == OP_EVAL) n_items++;
        idle_gap();
      end
    end

    // drain, then allow for the block's latency
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d evaluates checked, %0d with zero tangent, over %0d cycles",
             eval_count, zero_tan_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
